/* design/tst_pkg.sv */
// ----------------------------------------------------------------------------
// Timer slot table package
// Shared widths, item kinds and slot record types of the timer slot table.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int TIMER_SLOTS_DEF = 8;
  localparam int MAX_RESULTS     = 8;
  localparam int KEY_W           = 16;
  localparam int CNT_W           = 32;
  localparam int KIND_W          = 3;

  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PROCESS = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

  typedef struct packed {
    logic             cont;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] ticks;
    logic [KEY_W-1:0] key;
  } slot_rec_t;

  typedef struct packed {
    logic      rec_we;
    logic      ticks_we;
    slot_rec_t data;
  } slot_wr_t;

endpackage

/* design/tst_slot_store.sv */
// ----------------------------------------------------------------------------
// Timer slot store
// Slot records held in memories with a registered read port. A slot that was
// never written reads as all zeros.
// ----------------------------------------------------------------------------
module tst_slot_store #(
  parameter int  TIMER_SLOTS = tst_pkg::TIMER_SLOTS_DEF,
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SLOT_W-1:0]  addr,
  input  tst_pkg::slot_wr_t  wr,
  output tst_pkg::slot_rec_t rd
);
  import tst_pkg::*;

  logic             cont_mem  [TIMER_SLOTS];
  logic [CNT_W-1:0] limit_mem [TIMER_SLOTS];
  logic [CNT_W-1:0] ticks_mem [TIMER_SLOTS];
  logic [KEY_W-1:0] key_mem   [TIMER_SLOTS];

  logic [TIMER_SLOTS-1:0] written_r;
  logic                   seen_r;
  slot_rec_t              raw_r;

  always_ff @(posedge clk) begin
    if (wr.rec_we) begin
      cont_mem[addr]  <= wr.data.cont;
      limit_mem[addr] <= wr.data.limit;
      key_mem[addr]   <= wr.data.key;
    end
    if (wr.rec_we || wr.ticks_we) begin
      ticks_mem[addr] <= wr.data.ticks;
    end
    raw_r.cont  <= cont_mem[addr];
    raw_r.limit <= limit_mem[addr];
    raw_r.ticks <= ticks_mem[addr];
    raw_r.key   <= key_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      seen_r    <= 1'b0;
    end else begin
      seen_r <= written_r[addr];
      if (wr.rec_we) begin
        written_r[addr] <= 1'b1;
      end
    end
  end

  assign rd = seen_r ? raw_r : '0;

endmodule

/* design/timer_slot_table_core.sv */
// ----------------------------------------------------------------------------
// Timer slot table core
// Table of one-shot and continuous timer slots managed by key, walked one
// slot at a time by a small sequencer around a shared compare and add unit.
// ----------------------------------------------------------------------------
// Each item walks the slots in turn, with a memory read state and an execute
// state for every slot, then a done state that sends its final word. Unused
// kinds go straight to the done state. The input is not ready during the walk.
// A process item pauses its walk while its output word is not taken.
// Reset is synchronous and clears the enable, pending and written marks, so
// the whole table reads as zeros after reset.
module timer_slot_table_core #(
  parameter int TIMER_SLOTS = tst_pkg::TIMER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // key[15:0], mode[16], duration[48:17], zero fill
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // fired_key[15:0], counter_value[47:16]
  output logic [1:0]  out_tuser,  // status[0], fired[1]
  output logic        out_tlast
);
  import tst_pkg::*;

  localparam int SLOT_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int TAKEN_W = $clog2(MAX_RESULTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic [KIND_W-1:0]      kind_r, kind_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic                   mode_r, mode_nxt;
  logic [CNT_W-1:0]       dur_r, dur_nxt;
  logic                   found_a_r, found_a_nxt;
  logic                   found_b_r, found_b_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   held_v_r, held_v_nxt;
  logic [KEY_W-1:0]       held_key_r, held_key_nxt;
  logic [TAKEN_W-1:0]     taken_r, taken_nxt;
  logic [TIMER_SLOTS-1:0] slot_en_r, slot_en_nxt;
  logic [TIMER_SLOTS-1:0] slot_pend_r, slot_pend_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic             out_fired_r, out_fired_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic             out_last_r, out_last_nxt;

  slot_wr_t  wr;
  slot_rec_t rd;
  logic      can_push;
  logic      advance;
  logic      key_hit;
  logic      del_here;
  logic      free_here;

  tst_slot_store #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .addr (idx_r),
    .wr   (wr),
    .rd   (rd)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_key_r};
  assign out_tuser  = {out_fired_r, out_status_r};
  assign out_tlast  = out_last_r;
  assign can_push   = !out_valid_r || out_tready;

  assign key_hit   = (rd.key == key_r);
  assign del_here  = key_hit && !found_a_r;
  assign free_here = (!slot_en_r[idx_r] && !slot_pend_r[idx_r]) || del_here;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    mode_nxt       = mode_r;
    dur_nxt        = dur_r;
    found_a_nxt    = found_a_r;
    found_b_nxt    = found_b_r;
    cnt_nxt        = cnt_r;
    held_v_nxt     = held_v_r;
    held_key_nxt   = held_key_r;
    taken_nxt      = taken_r;
    slot_en_nxt    = slot_en_r;
    slot_pend_nxt  = slot_pend_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_fired_nxt  = out_fired_r;
    out_key_nxt    = out_key_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    wr             = '0;
    wr.data        = rd;
    advance        = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt    = in_tuser;
          key_nxt     = in_tdata[15:0];
          mode_nxt    = in_tdata[16];
          dur_nxt     = in_tdata[48:17];
          idx_nxt     = '0;
          found_a_nxt = 1'b0;
          found_b_nxt = 1'b0;
          cnt_nxt     = '0;
          held_v_nxt  = 1'b0;
          taken_nxt   = '0;
          state_nxt   = (in_tuser <= KIND_READ) ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (kind_r)
          KIND_TICK: begin
            if (slot_en_r[idx_r]) begin
              wr.ticks_we = 1'b1;
              if (rd.ticks >= rd.limit) begin
                slot_pend_nxt[idx_r] = 1'b1;
                wr.data.ticks        = '0;
                if (!rd.cont) begin
                  slot_en_nxt[idx_r] = 1'b0;
                end
              end else begin
                wr.data.ticks = rd.ticks + 1'b1;
              end
            end
          end
          KIND_CREATE: begin
            if (del_here) begin
              slot_en_nxt[idx_r]   = 1'b0;
              slot_pend_nxt[idx_r] = 1'b0;
              found_a_nxt          = 1'b1;
            end
            if (free_here && !found_b_r) begin
              wr.rec_we            = 1'b1;
              wr.data.cont         = mode_r;
              wr.data.limit        = dur_r;
              wr.data.ticks        = '0;
              wr.data.key          = key_r;
              slot_en_nxt[idx_r]   = 1'b1;
              slot_pend_nxt[idx_r] = 1'b0;
              found_b_nxt          = 1'b1;
            end
          end
          KIND_DELETE: begin
            if (del_here) begin
              slot_en_nxt[idx_r]   = 1'b0;
              slot_pend_nxt[idx_r] = 1'b0;
              found_a_nxt          = 1'b1;
            end
          end
          KIND_PROCESS: begin
            if (slot_pend_r[idx_r] && (taken_r < TAKEN_W'(MAX_RESULTS))) begin
              if (held_v_r && !can_push) begin
                advance = 1'b0;
              end else begin
                if (held_v_r) begin
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = 1'b0;
                  out_fired_nxt  = 1'b1;
                  out_key_nxt    = held_key_r;
                  out_cnt_nxt    = '0;
                  out_last_nxt   = 1'b0;
                end
                held_v_nxt           = 1'b1;
                held_key_nxt         = rd.key;
                slot_pend_nxt[idx_r] = 1'b0;
                taken_nxt            = taken_r + 1'b1;
              end
            end
          end
          KIND_READ: begin
            if (key_hit && slot_en_r[idx_r] && !found_a_r) begin
              cnt_nxt     = rd.ticks;
              found_a_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (advance) begin
          if (idx_r == LAST_SLOT) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_DONE: begin
        if (can_push) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ((kind_r == KIND_CREATE) && !found_b_r) ||
                           ((kind_r == KIND_DELETE) && !found_a_r);
          out_fired_nxt  = (kind_r == KIND_PROCESS) && held_v_r;
          out_key_nxt    = ((kind_r == KIND_PROCESS) && held_v_r) ? held_key_r : '0;
          out_cnt_nxt    = (kind_r == KIND_READ) ? cnt_r : '0;
          out_last_nxt   = 1'b1;
          held_v_nxt     = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_v_r    <= 1'b0;
      taken_r     <= '0;
      slot_en_r   <= '0;
      slot_pend_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_v_r    <= held_v_nxt;
      taken_r     <= taken_nxt;
      slot_en_r   <= slot_en_nxt;
      slot_pend_r <= slot_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    mode_r       <= mode_nxt;
    dur_r        <= dur_nxt;
    found_a_r    <= found_a_nxt;
    found_b_r    <= found_b_nxt;
    cnt_r        <= cnt_nxt;
    held_key_r   <= held_key_nxt;
    out_status_r <= out_status_nxt;
    out_fired_r  <= out_fired_nxt;
    out_key_r    <= out_key_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= TAKEN_W'(MAX_RESULTS))
    else $error("More pending slots reported than one item allows.");

  a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !held_v_r)
    else $error("A held fired key was left behind at the end of an item.");

  a_ticks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && kind_r == KIND_TICK && slot_en_r[idx_r]) |->
      (rd.ticks <= rd.limit))
    else $error("An enabled slot counted past its duration.");

  a_fired_process: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && can_push && held_v_r) |-> (kind_r == KIND_PROCESS))
    else $error("A fired key was raised by an item other than process.");

endmodule
